// File: rtl/core/ffaa_pkg.sv
// Shared types and constants of the first-fit arena allocator.
// Holds the controller states, the datapath command codes and the status struct.
// No dependencies.
`default_nettype none

package ffaa_pkg;

    // Arena geometry.
    localparam int ARENA_BYTES  = 4096;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 256;

    // Field and storage widths.
    localparam int OP_W   = 2;
    localparam int REQ_W  = 16;
    localparam int OFF_W  = 12;
    localparam int SZ_W   = 12;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int ENT_W  = IDX_W + 1;
    localparam int ADDR_W = SZ_W + 1;
    localparam int AL_W   = REQ_W + 1;
    localparam int CNT_W  = 32;
    localparam int LIVE_W = 8;

    // Output beat layout: five 12-bit fields, three counters, three 8-bit fields.
    localparam int OUT_BITS = 5 * SZ_W + 3 * CNT_W + 3 * LIVE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_W     = ((REQ_W + OFF_W + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_EV, S_A_CHK, S_SH_RD, S_SH_WR,
        S_A_INS, S_A_FIN, S_F_NRD, S_F_NEV, S_F_MRG, S_M_CHK, S_M_RD, S_M_WR,
        S_FAIL, S_IGN, S_ST_INIT, S_ST_RD, S_ST_EV, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_INIT, CMD_LOAD, CMD_RD_IDX, CMD_NEXT, CMD_HIT_A, CMD_SH_RD,
        CMD_SH_WR, CMD_A_INS, CMD_A_FIN, CMD_HIT_F, CMD_RD_NXT, CMD_F_NEXT,
        CMD_F_MRG, CMD_M_RD, CMD_M_WR, CMD_M_END, CMD_FAIL, CMD_ST_CLR,
        CMD_ST_ACC, CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic req_zero;
        logic off_zero;
        logic fit;
        logic match;
        logic rd_used;
        logic last;
        logic split;
        logic k_gt;
        logic m_more;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/first_fit_arena_allocator.sv
// First-fit arena allocator with coalescing, top level.
// Instantiates ffaa_ctrl and ffaa_dp; uses ffaa_pkg.
//
// Usage: one request beat enters on the s_axis side (tuser selects allocate,
// free or query), and exactly one result beat leaves on the m_axis side with
// the success flag in tuser and the offset plus all statistics in tdata.
// Requests are handled one at a time. An item passes through a first-fit
// or offset scan, any entry shifting for a split or merge, and a statistics
// pass over the table after the update, all through the single read port
// of the block table memory, which holds up to 256 entries.
// After reset the block writes the initial free block into the table and
// then raises s_axis_tready. A finished result sits in an
// output register; the next request is taken while it waits, but that
// request's result is held back until the receiver has taken the earlier beat.
`default_nettype none

module first_fit_arena_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: request_size[15:0], release_offset[27:16], zero fill [31:28]
    input  wire logic [ffaa_pkg::IN_W-1:0]     s_axis_tdata,
    // tuser: operation[1:0]
    input  wire logic [ffaa_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: payload_offset[11:0], in_use_bytes[23:12], peak_bytes[35:24],
    // alloc_total[67:36], free_total[99:68], fail_total[131:100],
    // live_count[139:132], peak_live[147:140], free_space[159:148],
    // largest_free[171:160], free_block_total[179:172], zero fill [183:180]
    output logic [ffaa_pkg::OUT_W-1:0]         m_axis_tdata,
    // tuser: ok
    output logic                               m_axis_tuser
);

    ffaa_pkg::t_cmd  w_cmd;
    ffaa_pkg::t_stat w_st;

    ffaa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_st          (w_st),
        .o_cmd         (w_cmd)
    );

    ffaa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_operation      (s_axis_tuser),
        .i_request_size   (s_axis_tdata[ffaa_pkg::REQ_W-1:0]),
        .i_release_offset (s_axis_tdata[ffaa_pkg::REQ_W +: ffaa_pkg::OFF_W]),
        .o_st             (w_st),
        .o_ok             (m_axis_tuser),
        .o_data           (m_axis_tdata)
    );

    // Only one request is in flight: after a beat is taken the port closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    // A failed or ignored result never reports a payload offset.
    a_no_offset_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[ffaa_pkg::SZ_W-1:0] == '0))
        else $error("offset reported on a failed result");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == ffaa_pkg::CMD_OUT) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/core/ffaa_ctrl.sv
// Controller state machine of the arena allocator.
// Sequences scans, shifts and statistics passes; uses ffaa_pkg.
`default_nettype none

module ffaa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire ffaa_pkg::t_stat i_st,
    output ffaa_pkg::t_cmd     o_cmd
);

    ffaa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ffaa_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;

    // State and output beat valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffaa_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Output beat valid: set on load, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        if (o_cmd == ffaa_pkg::CMD_OUT) begin
            n_out_valid = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffaa_pkg::S_INIT:    n_state = ffaa_pkg::S_IDLE;
            ffaa_pkg::S_IDLE:    if (s_axis_tvalid) n_state = ffaa_pkg::S_DISP;
            ffaa_pkg::S_DISP: begin
                if (i_st.is_alloc) begin
                    n_state = i_st.req_zero ? ffaa_pkg::S_FAIL : ffaa_pkg::S_SCAN_RD;
                end else if (i_st.is_free) begin
                    n_state = i_st.off_zero ? ffaa_pkg::S_IGN : ffaa_pkg::S_SCAN_RD;
                end else begin
                    n_state = ffaa_pkg::S_ST_INIT;
                end
            end
            ffaa_pkg::S_SCAN_RD: n_state = ffaa_pkg::S_SCAN_EV;
            ffaa_pkg::S_SCAN_EV: begin
                if (i_st.is_alloc) begin
                    if (i_st.fit)       n_state = ffaa_pkg::S_A_CHK;
                    else if (i_st.last) n_state = ffaa_pkg::S_FAIL;
                    else                n_state = ffaa_pkg::S_SCAN_RD;
                end else begin
                    if (i_st.match) begin
                        n_state = i_st.rd_used ? ffaa_pkg::S_F_NRD : ffaa_pkg::S_IGN;
                    end else if (i_st.last) begin
                        n_state = ffaa_pkg::S_IGN;
                    end else begin
                        n_state = ffaa_pkg::S_SCAN_RD;
                    end
                end
            end
            ffaa_pkg::S_A_CHK: begin
                if (i_st.split && i_st.k_gt) n_state = ffaa_pkg::S_SH_RD;
                else if (i_st.split)         n_state = ffaa_pkg::S_A_INS;
                else                         n_state = ffaa_pkg::S_A_FIN;
            end
            ffaa_pkg::S_SH_RD:   n_state = ffaa_pkg::S_SH_WR;
            ffaa_pkg::S_SH_WR:   n_state = ffaa_pkg::S_A_CHK;
            ffaa_pkg::S_A_INS:   n_state = ffaa_pkg::S_A_FIN;
            ffaa_pkg::S_A_FIN:   n_state = ffaa_pkg::S_ST_INIT;
            ffaa_pkg::S_F_NRD:   n_state = i_st.last ? ffaa_pkg::S_F_MRG : ffaa_pkg::S_F_NEV;
            ffaa_pkg::S_F_NEV:   n_state = ffaa_pkg::S_F_MRG;
            ffaa_pkg::S_F_MRG:   n_state = ffaa_pkg::S_M_CHK;
            ffaa_pkg::S_M_CHK:   n_state = i_st.m_more ? ffaa_pkg::S_M_RD : ffaa_pkg::S_ST_INIT;
            ffaa_pkg::S_M_RD:    n_state = ffaa_pkg::S_M_WR;
            ffaa_pkg::S_M_WR:    n_state = ffaa_pkg::S_M_CHK;
            ffaa_pkg::S_FAIL:    n_state = ffaa_pkg::S_ST_INIT;
            ffaa_pkg::S_IGN:     n_state = ffaa_pkg::S_ST_INIT;
            ffaa_pkg::S_ST_INIT: n_state = ffaa_pkg::S_ST_RD;
            ffaa_pkg::S_ST_RD:   n_state = ffaa_pkg::S_ST_EV;
            ffaa_pkg::S_ST_EV:   n_state = i_st.last ? ffaa_pkg::S_DONE : ffaa_pkg::S_ST_RD;
            ffaa_pkg::S_DONE:    if (w_out_free) n_state = ffaa_pkg::S_IDLE;
            default:             n_state = ffaa_pkg::S_INIT;
        endcase
    end

    // Datapath command for the current state.
    always_comb begin
        o_cmd = ffaa_pkg::CMD_NONE;
        case (r_state)
            ffaa_pkg::S_INIT:    o_cmd = ffaa_pkg::CMD_INIT;
            ffaa_pkg::S_IDLE:    if (s_axis_tvalid) o_cmd = ffaa_pkg::CMD_LOAD;
            ffaa_pkg::S_SCAN_RD: o_cmd = ffaa_pkg::CMD_RD_IDX;
            ffaa_pkg::S_SCAN_EV: begin
                if (i_st.is_alloc) begin
                    if (i_st.fit)        o_cmd = ffaa_pkg::CMD_HIT_A;
                    else if (!i_st.last) o_cmd = ffaa_pkg::CMD_NEXT;
                end else begin
                    if (i_st.match) begin
                        if (i_st.rd_used) o_cmd = ffaa_pkg::CMD_HIT_F;
                    end else if (!i_st.last) begin
                        o_cmd = ffaa_pkg::CMD_NEXT;
                    end
                end
            end
            ffaa_pkg::S_SH_RD:   o_cmd = ffaa_pkg::CMD_SH_RD;
            ffaa_pkg::S_SH_WR:   o_cmd = ffaa_pkg::CMD_SH_WR;
            ffaa_pkg::S_A_INS:   o_cmd = ffaa_pkg::CMD_A_INS;
            ffaa_pkg::S_A_FIN:   o_cmd = ffaa_pkg::CMD_A_FIN;
            ffaa_pkg::S_F_NRD:   if (!i_st.last) o_cmd = ffaa_pkg::CMD_RD_NXT;
            ffaa_pkg::S_F_NEV:   o_cmd = ffaa_pkg::CMD_F_NEXT;
            ffaa_pkg::S_F_MRG:   o_cmd = ffaa_pkg::CMD_F_MRG;
            ffaa_pkg::S_M_CHK:   if (!i_st.m_more) o_cmd = ffaa_pkg::CMD_M_END;
            ffaa_pkg::S_M_RD:    o_cmd = ffaa_pkg::CMD_M_RD;
            ffaa_pkg::S_M_WR:    o_cmd = ffaa_pkg::CMD_M_WR;
            ffaa_pkg::S_FAIL:    o_cmd = ffaa_pkg::CMD_FAIL;
            ffaa_pkg::S_ST_INIT: o_cmd = ffaa_pkg::CMD_ST_CLR;
            ffaa_pkg::S_ST_RD:   o_cmd = ffaa_pkg::CMD_RD_IDX;
            ffaa_pkg::S_ST_EV:   o_cmd = ffaa_pkg::CMD_ST_ACC;
            ffaa_pkg::S_DONE:    if (w_out_free) o_cmd = ffaa_pkg::CMD_OUT;
            default:             o_cmd = ffaa_pkg::CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ffaa_dp.sv
// Datapath of the arena allocator: block table memory, scan registers and statistics.
// Driven by commands from ffaa_ctrl; uses ffaa_pkg.
`default_nettype none

module ffaa_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffaa_pkg::t_cmd                i_cmd,
    input  wire logic [ffaa_pkg::OP_W-1:0]     i_operation,
    input  wire logic [ffaa_pkg::REQ_W-1:0]    i_request_size,
    input  wire logic [ffaa_pkg::OFF_W-1:0]    i_release_offset,
    output ffaa_pkg::t_stat                    o_st,
    output logic                               o_ok,
    output logic [ffaa_pkg::OUT_W-1:0]         o_data
);

    localparam int SZ_W   = ffaa_pkg::SZ_W;
    localparam int IDX_W  = ffaa_pkg::IDX_W;
    localparam int ENT_W  = ffaa_pkg::ENT_W;
    localparam int ADDR_W = ffaa_pkg::ADDR_W;
    localparam int AL_W   = ffaa_pkg::AL_W;
    localparam int CNT_W  = ffaa_pkg::CNT_W;
    localparam int LIVE_W = ffaa_pkg::LIVE_W;

    localparam logic [SZ_W-1:0]   HDR_SZ   = SZ_W'(ffaa_pkg::HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HDR_AD   = ADDR_W'(ffaa_pkg::HEADER_BYTES);
    localparam logic [SZ_W-1:0]   SPLIT_MIN = SZ_W'(ffaa_pkg::HEADER_BYTES + ffaa_pkg::ALIGN_BYTES);
    localparam logic [SZ_W-1:0]   INIT_SZ  = SZ_W'(ffaa_pkg::ARENA_BYTES - ffaa_pkg::HEADER_BYTES);
    localparam logic [AL_W-1:0]   AL_ADD   = AL_W'(ffaa_pkg::ALIGN_BYTES - 1);
    localparam logic [AL_W-1:0]   AL_MASK  = ~AL_W'(ffaa_pkg::ALIGN_BYTES - 1);
    localparam logic [ENT_W-1:0]  MAX_ENT  = ENT_W'(ffaa_pkg::MAX_BLOCKS);
    localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

    // Block table: used mark above the payload size.
    logic [SZ_W:0] mem [ffaa_pkg::MAX_BLOCKS];

    logic [SZ_W:0]       r_rd;
    logic [ffaa_pkg::OP_W-1:0] r_op;
    logic [AL_W-1:0]     r_aligned;
    logic                r_req_zero;
    logic [ffaa_pkg::OFF_W-1:0] r_off;
    logic [IDX_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_addr;
    logic [ENT_W-1:0]    r_entries;
    logic                r_prev_free, r_next_free, r_split;
    logic [SZ_W-1:0]     r_prev_size, r_next_size, r_hit_size, r_rest;
    logic [ENT_W-1:0]    r_k;
    logic [1:0]          r_rm;
    logic                r_ok;
    logic [SZ_W-1:0]     r_payload;
    logic [SZ_W-1:0]     r_used_bytes, r_peak_bytes;
    logic [CNT_W-1:0]    r_alloc_cnt, r_free_cnt, r_fail_cnt;
    logic [LIVE_W-1:0]   r_live, r_peak_live;
    logic [LIVE_W-1:0]   r_fcount;
    logic [SZ_W-1:0]     r_fbytes, r_largest;
    logic                r_out_ok;
    logic [ffaa_pkg::OUT_W-1:0] r_out_data;

    logic [SZ_W-1:0]     w_rd_size;
    logic                w_rd_used;
    logic [ADDR_W-1:0]   w_addr_hdr;
    logic [SZ_W-1:0]     w_rest;
    logic [ENT_W-1:0]    w_idx1, w_krm;
    logic [SZ_W-1:0]     w_a_size, w_n_used, w_total;
    logic [LIVE_W-1:0]   w_n_live;
    logic [IDX_W-1:0]    w_start, w_raddr, w_waddr;
    logic                w_we, w_re;
    logic [SZ_W:0]       w_wdata;

    assign w_rd_size  = r_rd[SZ_W-1:0];
    assign w_rd_used  = r_rd[SZ_W];
    assign w_addr_hdr = r_addr + HDR_AD;
    assign w_rest     = w_rd_size - r_aligned[SZ_W-1:0];
    assign w_idx1     = {1'b0, r_idx} + ENT_W'(1);
    assign w_krm      = r_k + ENT_W'(r_rm);
    assign w_a_size   = r_split ? r_aligned[SZ_W-1:0] : r_hit_size;
    assign w_n_used   = r_used_bytes + w_a_size;
    assign w_n_live   = (r_live == LIVE_MAX) ? r_live : r_live + LIVE_W'(1);
    assign w_start    = r_prev_free ? r_idx - IDX_W'(1) : r_idx;
    assign w_total    = r_hit_size
                      + (r_prev_free ? r_prev_size + HDR_SZ : '0)
                      + (r_next_free ? r_next_size + HDR_SZ : '0);

    // Status toward the controller.
    always_comb begin
        o_st.is_alloc = (r_op == ffaa_pkg::OP_ALLOC);
        o_st.is_free  = (r_op == ffaa_pkg::OP_FREE);
        o_st.req_zero = r_req_zero;
        o_st.off_zero = (r_off == '0);
        o_st.fit      = !w_rd_used && ({{(AL_W-SZ_W){1'b0}}, w_rd_size} >= r_aligned);
        o_st.match    = (w_addr_hdr == {1'b0, r_off});
        o_st.rd_used  = w_rd_used;
        o_st.last     = (w_idx1 == r_entries);
        o_st.split    = r_split;
        o_st.k_gt     = (r_k > w_idx1);
        o_st.m_more   = (w_krm < r_entries);
    end

    // Table port addresses and write data.
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_rd;
        case (i_cmd)
            ffaa_pkg::CMD_RD_IDX: w_re = 1'b1;
            ffaa_pkg::CMD_RD_NXT: begin
                w_re    = 1'b1;
                w_raddr = w_idx1[IDX_W-1:0];
            end
            ffaa_pkg::CMD_SH_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k[IDX_W-1:0] - IDX_W'(1);
            end
            ffaa_pkg::CMD_M_RD: begin
                w_re    = 1'b1;
                w_raddr = w_krm[IDX_W-1:0];
            end
            ffaa_pkg::CMD_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {1'b0, INIT_SZ};
            end
            ffaa_pkg::CMD_SH_WR, ffaa_pkg::CMD_M_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IDX_W-1:0];
            end
            ffaa_pkg::CMD_A_INS: begin
                w_we    = 1'b1;
                w_waddr = w_idx1[IDX_W-1:0];
                w_wdata = {1'b0, r_rest - HDR_SZ};
            end
            ffaa_pkg::CMD_A_FIN: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, w_a_size};
            end
            ffaa_pkg::CMD_F_MRG: begin
                w_we    = 1'b1;
                w_waddr = w_start;
                w_wdata = {1'b0, w_total};
            end
            default: w_we = 1'b0;
        endcase
    end

    // Block table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    // Table length and running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries    <= ENT_W'(1);
            r_used_bytes <= '0;
            r_peak_bytes <= '0;
            r_alloc_cnt  <= '0;
            r_free_cnt   <= '0;
            r_fail_cnt   <= '0;
            r_live       <= '0;
            r_peak_live  <= '0;
        end else begin
            case (i_cmd)
                ffaa_pkg::CMD_INIT: r_entries <= ENT_W'(1);
                ffaa_pkg::CMD_A_FIN: begin
                    r_entries    <= r_entries + ENT_W'(r_split);
                    r_used_bytes <= w_n_used;
                    if (w_n_used > r_peak_bytes) r_peak_bytes <= w_n_used;
                    r_alloc_cnt  <= r_alloc_cnt + CNT_W'(1);
                    r_live       <= w_n_live;
                    if (w_n_live > r_peak_live) r_peak_live <= w_n_live;
                end
                ffaa_pkg::CMD_HIT_F: begin
                    r_used_bytes <= (r_used_bytes >= w_rd_size) ? r_used_bytes - w_rd_size : '0;
                    if (r_live != '0) r_live <= r_live - LIVE_W'(1);
                    r_free_cnt   <= r_free_cnt + CNT_W'(1);
                end
                ffaa_pkg::CMD_M_END: r_entries <= r_entries - ENT_W'(r_rm);
                ffaa_pkg::CMD_FAIL:  r_fail_cnt <= r_fail_cnt + CNT_W'(1);
                default: r_entries <= r_entries;
            endcase
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ffaa_pkg::CMD_LOAD: begin
                r_op        <= i_operation;
                r_aligned   <= ({1'b0, i_request_size} + AL_ADD) & AL_MASK;
                r_req_zero  <= (i_request_size == '0);
                r_off       <= i_release_offset;
                r_idx       <= '0;
                r_addr      <= '0;
                r_prev_free <= 1'b0;
                r_ok        <= (i_operation != ffaa_pkg::OP_ALLOC) &&
                               (i_operation != ffaa_pkg::OP_FREE);
                r_payload   <= '0;
            end
            ffaa_pkg::CMD_NEXT: begin
                r_prev_free <= !w_rd_used;
                r_prev_size <= w_rd_size;
                r_idx       <= r_idx + IDX_W'(1);
                r_addr      <= w_addr_hdr + {1'b0, w_rd_size};
            end
            ffaa_pkg::CMD_HIT_A: begin
                r_hit_size <= w_rd_size;
                r_rest     <= w_rest;
                r_split    <= (w_rest > SPLIT_MIN) && (r_entries < MAX_ENT);
                r_payload  <= w_addr_hdr[SZ_W-1:0];
                r_k        <= r_entries;
            end
            ffaa_pkg::CMD_SH_WR: r_k <= r_k - ENT_W'(1);
            ffaa_pkg::CMD_A_FIN: r_ok <= 1'b1;
            ffaa_pkg::CMD_HIT_F: begin
                r_hit_size  <= w_rd_size;
                r_next_free <= 1'b0;
                r_ok        <= 1'b1;
            end
            ffaa_pkg::CMD_F_NEXT: begin
                r_next_free <= !w_rd_used;
                r_next_size <= w_rd_size;
            end
            ffaa_pkg::CMD_F_MRG: begin
                r_rm <= {1'b0, r_prev_free} + {1'b0, r_next_free};
                r_k  <= {1'b0, w_start} + ENT_W'(1);
            end
            ffaa_pkg::CMD_M_WR: r_k <= r_k + ENT_W'(1);
            ffaa_pkg::CMD_ST_CLR: begin
                r_idx     <= '0;
                r_fcount  <= '0;
                r_fbytes  <= '0;
                r_largest <= '0;
            end
            ffaa_pkg::CMD_ST_ACC: begin
                r_idx <= r_idx + IDX_W'(1);
                if (!w_rd_used) begin
                    r_fcount <= r_fcount + LIVE_W'(1);
                    r_fbytes <= r_fbytes + w_rd_size;
                    if (w_rd_size > r_largest) r_largest <= w_rd_size;
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (i_cmd == ffaa_pkg::CMD_OUT) begin
            r_out_ok   <= r_ok;
            r_out_data <= ffaa_pkg::OUT_W'({r_fcount, r_largest, r_fbytes, r_peak_live,
                                            r_live, r_fail_cnt, r_free_cnt, r_alloc_cnt,
                                            r_peak_bytes, r_used_bytes, r_payload});
        end
    end

    assign o_ok   = r_out_ok;
    assign o_data = r_out_data;

endmodule

`default_nettype wire
